// ===== rtl/core/lpm_pkg.sv =====
// Shared types and constants of the LIKE pattern matcher.
// Holds request codes, token kinds, escape states and the beat payloads.
// Depends on nothing; every other file of the block but lpm_chan_if refers to it.
`default_nettype none

package lpm_pkg;

	typedef enum logic [1:0] {
		REQ_PAT_BYTE  = 2'd0,
		REQ_PAT_END   = 2'd1,
		REQ_SUBJ_BYTE = 2'd2,
		REQ_SUBJ_END  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_LIT = 2'd0,
		KIND_ONE = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	// Escape tracking while the pattern is loaded; CLOSED marks a finished pattern.
	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_SLASH  = 2'd1,
		ESC_STAR   = 2'd2,
		ESC_CLOSED = 2'd3
	} esc_t;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] chr;
	} tok_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic match_result;
		logic pattern_overflow;
	} out_item_t;

	// Up to two tokens written per pattern byte, in order, at the token count.
	typedef struct packed {
		logic commit;
		logic v0;
		tok_t tok0;
		logic v1;
		tok_t tok1;
	} tok_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpm_chan_if.sv =====
// Valid/ready channel carrying one payload per beat.
// The payload type is set where the channel is instantiated; no dependencies.
`default_nettype none

interface lpm_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpm_token_ctrl.sv =====
// Pattern tokenizer: escape state, token count and overflow flag.
// Turns pattern bytes and pattern closes into token writes. Uses lpm_pkg.
`default_nettype none

module lpm_token_ctrl #(
	parameter int MAX_TOKENS = 64,
	localparam int CNT_W = $clog2(MAX_TOKENS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  lpm_pkg::req_t      req,
	input  logic [7:0]         chr,
	output lpm_pkg::tok_wr_t   wr,
	output logic [CNT_W-1:0]   base,
	output logic [CNT_W-1:0]   count_d,
	output logic               ovf_d,
	output logic               restart
);

	lpm_pkg::esc_t     esc_q, esc_d, esc_eff;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q, ovf_base;
	logic              pre_v, pl_v, plain_go, over;
	lpm_pkg::tok_t     pre_tok, pl_tok;
	logic [CNT_W:0]    sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= lpm_pkg::ESC_NONE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (fire) begin
			esc_q   <= esc_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
		end
	end

	always_comb begin
		esc_d    = esc_q;
		esc_eff  = esc_q;
		base     = count_q;
		ovf_base = ovf_q;
		restart  = 1'b0;
		pre_v    = 1'b0;
		pre_tok  = '{kind: lpm_pkg::KIND_LIT, chr: lpm_pkg::CH_SLASH};
		pl_v     = 1'b0;
		pl_tok   = '{kind: lpm_pkg::KIND_LIT, chr: chr};
		plain_go = 1'b1;
		case (req)
			lpm_pkg::REQ_PAT_BYTE: begin
				// A byte after a closed pattern starts a new one.
				if (esc_q == lpm_pkg::ESC_CLOSED) begin
					base     = '0;
					ovf_base = 1'b0;
					restart  = 1'b1;
					esc_eff  = lpm_pkg::ESC_NONE;
				end
				esc_d = lpm_pkg::ESC_NONE;
				case (esc_eff)
					lpm_pkg::ESC_SLASH: begin
						pre_v = 1'b1;
						if (chr == lpm_pkg::CH_PERCENT || chr == lpm_pkg::CH_UNDER ||
								chr == lpm_pkg::CH_SLASH) begin
							pre_tok  = '{kind: lpm_pkg::KIND_LIT, chr: chr};
							plain_go = 1'b0;
						end
					end
					lpm_pkg::ESC_STAR: begin
						pre_v = 1'b1;
						if (chr == lpm_pkg::CH_STAR) begin
							pre_tok  = '{kind: lpm_pkg::KIND_LIT, chr: lpm_pkg::CH_STAR};
							plain_go = 1'b0;
						end else begin
							pre_tok = '{kind: lpm_pkg::KIND_RUN, chr: 8'h00};
						end
					end
					default: begin
					end
				endcase
				if (plain_go) begin
					if (chr == lpm_pkg::CH_PERCENT) begin
						pl_v   = 1'b1;
						pl_tok = '{kind: lpm_pkg::KIND_RUN, chr: 8'h00};
					end else if (chr == lpm_pkg::CH_STAR) begin
						esc_d = lpm_pkg::ESC_STAR;
					end else if (chr == lpm_pkg::CH_UNDER) begin
						pl_v   = 1'b1;
						pl_tok = '{kind: lpm_pkg::KIND_ONE, chr: 8'h00};
					end else if (chr == lpm_pkg::CH_SLASH) begin
						esc_d = lpm_pkg::ESC_SLASH;
					end else begin
						pl_v = 1'b1;
					end
				end
			end
			default: begin
				// Every other request closes an open pattern first.
				if (esc_q != lpm_pkg::ESC_CLOSED) begin
					restart = 1'b1;
					esc_d   = lpm_pkg::ESC_CLOSED;
					if (esc_q == lpm_pkg::ESC_SLASH) begin
						pre_v = 1'b1;
					end else if (esc_q == lpm_pkg::ESC_STAR) begin
						pre_v   = 1'b1;
						pre_tok = '{kind: lpm_pkg::KIND_RUN, chr: 8'h00};
					end
				end
			end
		endcase
	end

	always_comb begin
		wr.commit = fire;
		wr.v0     = pre_v | pl_v;
		wr.tok0   = pre_v ? pre_tok : pl_tok;
		wr.v1     = pre_v & pl_v;
		wr.tok1   = pl_tok;
		sum       = {1'b0, base} + (CNT_W + 1)'(wr.v0) + (CNT_W + 1)'(wr.v1);
		over      = sum > (CNT_W + 1)'(MAX_TOKENS);
		count_d   = over ? CNT_W'(MAX_TOKENS) : sum[CNT_W-1:0];
		ovf_d     = ovf_base | over;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TOKENS))
		else $error("token count above store size");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CNT_W'(MAX_TOKENS))
		else $error("overflow flagged with free token slots");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lpm_token_store.sv =====
// Token store: one register per pattern position, written at the token count.
// Presents per-position run and advance masks, with this beat's writes forwarded.
// Uses lpm_pkg.
`default_nettype none

module lpm_token_store #(
	parameter int MAX_TOKENS = 64,
	localparam int CNT_W = $clog2(MAX_TOKENS + 1)
) (
	input  logic                   clk,
	input  lpm_pkg::tok_wr_t       wr,
	input  logic [CNT_W-1:0]       base,
	input  logic [7:0]             chr,
	output logic [MAX_TOKENS-1:0]  run_m,
	output logic [MAX_TOKENS-1:0]  adv_m
);

	logic [CNT_W:0] base_p1;

	assign base_p1 = {1'b0, base} + (CNT_W + 1)'(1);

	for (genvar p = 0; p < MAX_TOKENS; p++) begin : g_ent
		lpm_pkg::tok_t tok_q, tok_eff;
		logic          hit0, hit1;

		assign hit0 = wr.v0 && (base == CNT_W'(p));
		assign hit1 = wr.v1 && (base_p1 == (CNT_W + 1)'(p));

		always_comb begin
			if (hit0) begin
				tok_eff = wr.tok0;
			end else if (hit1) begin
				tok_eff = wr.tok1;
			end else begin
				tok_eff = tok_q;
			end
		end

		always_ff @(posedge clk) begin
			if (wr.commit && (hit0 || hit1)) begin
				tok_q <= tok_eff;
			end
		end

		assign run_m[p] = tok_eff.kind == lpm_pkg::KIND_RUN;
		assign adv_m[p] = (tok_eff.kind == lpm_pkg::KIND_ONE) ||
			(tok_eff.kind == lpm_pkg::KIND_LIT && tok_eff.chr == chr);
	end

endmodule

`default_nettype wire

// ===== rtl/core/lpm_match.sv =====
// Active-position vector with run-wildcard closure and one-byte advance.
// The closure along chains of run tokens is a carry chain, done by one add.
// Uses lpm_pkg.
`default_nettype none

module lpm_match #(
	parameter int MAX_TOKENS = 64,
	localparam int CNT_W = $clog2(MAX_TOKENS + 1),
	localparam int POS_W = MAX_TOKENS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  lpm_pkg::req_t          req,
	input  logic                   restart,
	input  logic [CNT_W-1:0]       count_e,
	input  logic [MAX_TOKENS-1:0]  run_m,
	input  logic [MAX_TOKENS-1:0]  adv_m,
	output logic                   hit
);

	logic [POS_W-1:0]      act_q, act_d, act_in, prop, x_op, sum, cin, clo, stepped;
	logic [MAX_TOKENS-1:0] live, from;

	for (genvar p = 0; p < MAX_TOKENS; p++) begin : g_live
		assign live[p] = count_e > CNT_W'(p);
	end

	always_comb begin
		act_in  = restart ? POS_W'(1) : act_q;
		// Position q+1 is reachable from q through a run token at q.
		prop    = {run_m & live, 1'b0};
		x_op    = act_in | prop;
		sum     = x_op + act_in;
		cin     = sum ^ x_op ^ act_in;
		clo     = act_in | (prop & cin);
		hit     = clo[count_e];
		from    = clo[MAX_TOKENS-1:0] & live;
		stepped = {1'b0, from & run_m} | {from & (run_m | adv_m), 1'b0};
		case (req)
			lpm_pkg::REQ_SUBJ_BYTE: act_d = stepped;
			lpm_pkg::REQ_SUBJ_END:  act_d = POS_W'(1);
			default:                act_d = act_in;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= POS_W'(1);
		end else if (fire) begin
			act_q <= act_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/like_pattern_matcher.sv =====
// Case-sensitive SQL LIKE matcher. Send the pattern as pattern-byte beats
// (% or a lone * matches any run, _ one byte, ** a literal star, a slash
// before %, _ or / makes it literal), then subject bytes, then an
// end-of-subject beat, which alone returns a result beat carrying the
// whole-string match (inverted when invert_mode is 1) and the overflow flag
// for patterns of more than MAX_TOKENS tokens. The block takes one beat
// every cycle while it does not stall: a beat lands in the input
// register, the token and position update runs from there, and the
// result of an end-of-subject beat is written into the output register
// as that beat leaves the input register. The input only stalls when an
// end-of-subject beat waits behind a result that the sink has not yet
// taken. The token store is MAX_TOKENS flip-flop entries with no
// clearing pass, so the block is ready right after reset. Write
// invert_mode only while the block is idle.
// Uses lpm_pkg, lpm_chan_if, lpm_token_ctrl, lpm_token_store and lpm_match.
`default_nettype none

module like_pattern_matcher #(
	parameter int MAX_TOKENS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	lpm_chan_if.sink      item,
	lpm_chan_if.source    result,
	lpm_chan_if.sink      cfg
);

	localparam int CNT_W = $clog2(MAX_TOKENS + 1);

	// Input register stage.
	logic                  valid_s1;
	lpm_pkg::in_item_t     item_s1;
	lpm_pkg::req_t         req_s1;
	logic                  eos_s1, stall, fire;

	// Output register.
	logic                  result_valid_q;
	lpm_pkg::out_item_t    result_q;

	logic                  invert_q;

	lpm_pkg::tok_wr_t      wr;
	logic [CNT_W-1:0]      base, count_d;
	logic                  ovf_d, restart, hit;
	logic [MAX_TOKENS-1:0] run_m, adv_m;

	assign req_s1 = lpm_pkg::req_t'(item_s1.req_type);
	assign eos_s1 = valid_s1 && (req_s1 == lpm_pkg::REQ_SUBJ_END);

	// An end-of-subject beat can only leave when the output register frees up.
	assign stall      = eos_s1 && result_valid_q && !result.ready;
	assign fire       = valid_s1 && !stall;
	assign item.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	// Configuration: a single register, always writable.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg.valid) begin
			invert_q <= cfg.payload;
		end
	end

	lpm_token_ctrl #(
		.MAX_TOKENS (MAX_TOKENS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.req     (req_s1),
		.chr     (item_s1.char_byte),
		.wr      (wr),
		.base    (base),
		.count_d (count_d),
		.ovf_d   (ovf_d),
		.restart (restart)
	);

	// The store forwards this beat's writes, so a subject beat that closes
	// the pattern already sees the token that the close appends.
	lpm_token_store #(
		.MAX_TOKENS (MAX_TOKENS)
	) u_store (
		.clk   (clk),
		.wr    (wr),
		.base  (base),
		.chr   (item_s1.char_byte),
		.run_m (run_m),
		.adv_m (adv_m)
	);

	lpm_match #(
		.MAX_TOKENS (MAX_TOKENS)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.req     (req_s1),
		.restart (restart),
		.count_e (count_d),
		.run_m   (run_m),
		.adv_m   (adv_m),
		.hit     (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && eos_s1) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && eos_s1) begin
			result_q.match_result     <= hit ^ invert_q;
			result_q.pattern_overflow <= ovf_d;
		end
	end

	assign result.valid   = result_valid_q;
	assign result.payload = result_q;

`ifndef SYNTHESIS
	a_eos_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && eos_s1) |=> result_valid_q)
		else $error("end-of-subject beat left no result beat");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled beat lost from the input register");
`endif

endmodule

`default_nettype wire

// ===== test/like_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for like_pattern_matcher: random patterns and subjects with
// bursty input and a stalling result sink, checked against a cycle-free matcher model.
// Depends on lpm_pkg, lpm_chan_if and the like_pattern_matcher RTL.

module like_pattern_matcher_tb;
	import lpm_pkg::*;

	localparam int MAX_TOKENS = 64;
	// Worst case per beat is a long sender gap plus the longest sink stall, so
	// this cap is many times the slowest correct run.
	localparam int CYCLE_LIMIT = 400000;

	// Shapes of pattern pieces that the stimulus builds.
	// Each piece knows how to emit its pattern bytes and a matching subject fragment.
	typedef enum logic [3:0] {
		PC_LIT,
		PC_PCT,
		PC_STAR,
		PC_ONE,
		PC_STAR_LIT,
		PC_ESC,
		PC_SLASH_LIT,
		PC_TAIL_SLASH,
		PC_TAIL_STAR
	} piece_t;

	// Modes of the result sink's stall pattern.
	typedef enum logic [1:0] {
		RX_STEADY,
		RX_STALL,
		RX_FLICKER
	} rx_mode_t;

	localparam logic [7:0] SUBJ_MIX [7] = '{8'h61, 8'h62, 8'h63, CH_STAR, CH_PERCENT,
		CH_UNDER, CH_SLASH};

	logic clk = 1'b0;
	logic arst_n;

	lpm_chan_if #(.payload_t(in_item_t))  item_ch ();
	lpm_chan_if #(.payload_t(out_item_t)) result_ch ();
	lpm_chan_if #(.payload_t(logic))      cfg_ch ();

	like_pattern_matcher #(.MAX_TOKENS(MAX_TOKENS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Matcher model. It mirrors the block's architectural state: the token
	// list, the escape tracker, the live-position vector, the overflow flag
	// and invert_mode. Bit p of live_pos means the first p tokens can have
	// consumed the subject bytes seen so far.
	// ------------------------------------------------------------------
	kind_t               tok_kind [MAX_TOKENS];
	logic [7:0]          tok_chr [MAX_TOKENS];
	int unsigned         tok_cnt = 0;
	esc_t                esc_state = ESC_NONE;
	logic [MAX_TOKENS:0] live_pos = 1;
	logic                ovf_seen = 1'b0;
	logic                invert_on = 1'b0;

	// Verdicts that end-of-subject beats have produced but the sink has not yet taken.
	out_item_t           verdicts [$];

	task automatic restart_live();
		live_pos = '0;
		live_pos[0] = 1'b1;
	endtask

	// Tokens past the store size are dropped; only the flag remembers them.
	task automatic add_token(kind_t k, logic [7:0] c);
		if (tok_cnt >= MAX_TOKENS) begin
			ovf_seen = 1'b1;
		end else begin
			tok_kind[tok_cnt] = k;
			tok_chr[tok_cnt] = c;
			tok_cnt++;
		end
	endtask

	task automatic plain_pattern_byte(logic [7:0] c);
		case (c)
			CH_PERCENT: add_token(KIND_RUN, 8'h00);
			CH_STAR:    esc_state = ESC_STAR;
			CH_UNDER:   add_token(KIND_ONE, 8'h00);
			CH_SLASH:   esc_state = ESC_SLASH;
			default:    add_token(KIND_LIT, c);
		endcase
	endtask

	task automatic load_pattern_byte(logic [7:0] c);
		esc_t held;
		held = esc_state;
		// A pattern byte after a closed pattern starts a fresh one.
		if (held == ESC_CLOSED) begin
			tok_cnt = 0;
			ovf_seen = 1'b0;
			restart_live();
			held = ESC_NONE;
		end
		esc_state = ESC_NONE;
		if (held == ESC_SLASH) begin
			if (c == CH_PERCENT || c == CH_UNDER || c == CH_SLASH) begin
				add_token(KIND_LIT, c);
				return;
			end
			add_token(KIND_LIT, CH_SLASH);
		end else if (held == ESC_STAR) begin
			if (c == CH_STAR) begin
				add_token(KIND_LIT, CH_STAR);
				return;
			end
			add_token(KIND_RUN, 8'h00);
		end
		plain_pattern_byte(c);
	endtask

	// Closing flushes a held slash or star; a second close does nothing.
	task automatic close_pattern();
		if (esc_state == ESC_CLOSED)
			return;
		if (esc_state == ESC_SLASH)
			add_token(KIND_LIT, CH_SLASH);
		else if (esc_state == ESC_STAR)
			add_token(KIND_RUN, 8'h00);
		esc_state = ESC_CLOSED;
		restart_live();
	endtask

	// A live run token may match nothing, so it also makes the next position live.
	// Walking upward lets chains of runs propagate in one pass.
	task automatic spread_runs();
		for (int p = 0; p < tok_cnt; p++)
			if (live_pos[p] && tok_kind[p] == KIND_RUN)
				live_pos[p + 1] = 1'b1;
	endtask

	task automatic step_subject(logic [7:0] c);
		logic [MAX_TOKENS:0] nxt;
		nxt = '0;
		spread_runs();
		for (int p = 0; p < tok_cnt; p++) begin
			if (live_pos[p]) begin
				if (tok_kind[p] == KIND_RUN) begin
					nxt[p] = 1'b1;
					nxt[p + 1] = 1'b1;
				end else if (tok_kind[p] == KIND_ONE || tok_chr[p] == c) begin
					nxt[p + 1] = 1'b1;
				end
			end
		end
		live_pos = nxt;
		spread_runs();
	endtask

	// Applies one accepted input beat; only end of subject yields a verdict.
	task automatic predict_beat(in_item_t it);
		out_item_t v;
		case (it.req_type)
			REQ_PAT_BYTE: load_pattern_byte(it.char_byte);
			REQ_PAT_END:  close_pattern();
			REQ_SUBJ_BYTE: begin
				close_pattern();
				step_subject(it.char_byte);
			end
			default: begin
				close_pattern();
				spread_runs();
				v.match_result = live_pos[tok_cnt] ^ invert_on;
				v.pattern_overflow = ovf_seen;
				verdicts.insert(verdicts.size(), v);
				restart_live();
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stimulus generation. The initial block fills pending_beats; the driver
	// drains it. Patterns are built from pieces whose meaning is known, so a
	// subject that should match can be derived and then optionally broken.
	// ------------------------------------------------------------------
	in_item_t    pending_beats [$];
	int unsigned beats_queued = 0;
	piece_t      pieces [$];
	logic [7:0]  piece_chr [$];
	logic [7:0]  subj_bytes [$];

	task automatic send(req_t r, logic [7:0] c);
		in_item_t it;
		it.req_type = r;
		it.char_byte = c;
		pending_beats.insert(pending_beats.size(), it);
		beats_queued++;
	endtask

	function automatic logic [7:0] pick_literal();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0)
			return 8'h61 + 8'($urandom_range(0, 2));
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_PERCENT || c == CH_STAR || c == CH_UNDER || c == CH_SLASH);
		return c;
	endfunction

	// A lone star right before another star would turn into a literal star,
	// so such a star is written as a percent instead.
	task automatic add_piece(piece_t s, logic [7:0] c);
		if ((s == PC_STAR || s == PC_STAR_LIT || s == PC_TAIL_STAR) && pieces.size() != 0
				&& pieces[pieces.size() - 1] == PC_STAR)
			pieces[pieces.size() - 1] = PC_PCT;
		pieces.insert(pieces.size(), s);
		piece_chr.insert(piece_chr.size(), c);
	endtask

	task automatic make_pattern(int n);
		logic [7:0] esc_pick [3];
		esc_pick = '{CH_PERCENT, CH_UNDER, CH_SLASH};
		pieces.delete();
		piece_chr.delete();
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3, 4: add_piece(PC_LIT, pick_literal());
				5:             add_piece(PC_PCT, 8'h00);
				6:             add_piece(PC_STAR, 8'h00);
				7, 11:         add_piece(PC_ONE, 8'h00);
				8:             add_piece(PC_STAR_LIT, 8'h00);
				9:             add_piece(PC_ESC, esc_pick[$urandom_range(0, 2)]);
				default:       add_piece(PC_SLASH_LIT, 8'h61 + 8'($urandom_range(0, 2)));
			endcase
		end
		// A trailing slash or star is still held when the pattern closes.
		if ($urandom_range(0, 5) == 0) begin
			if ($urandom_range(0, 1) != 0)
				add_piece(PC_TAIL_SLASH, 8'h00);
			else
				add_piece(PC_TAIL_STAR, 8'h00);
		end
		foreach (pieces[i]) begin
			case (pieces[i])
				PC_LIT:       send(REQ_PAT_BYTE, piece_chr[i]);
				PC_PCT:       send(REQ_PAT_BYTE, CH_PERCENT);
				PC_STAR, PC_TAIL_STAR: send(REQ_PAT_BYTE, CH_STAR);
				PC_ONE:       send(REQ_PAT_BYTE, CH_UNDER);
				PC_STAR_LIT: begin
					send(REQ_PAT_BYTE, CH_STAR);
					send(REQ_PAT_BYTE, CH_STAR);
				end
				PC_ESC, PC_SLASH_LIT: begin
					send(REQ_PAT_BYTE, CH_SLASH);
					send(REQ_PAT_BYTE, piece_chr[i]);
				end
				default:      send(REQ_PAT_BYTE, CH_SLASH);
			endcase
		end
	endtask

	// Most subjects are built to match; some of those get one byte changed,
	// dropped or added, and the rest are short random strings.
	task automatic make_subject();
		int unsigned pick;
		int unsigned pos;
		pick = $urandom_range(0, 9);
		subj_bytes.delete();
		if (pick >= 8) begin
			repeat ($urandom_range(0, 6))
				subj_bytes.insert(subj_bytes.size(), SUBJ_MIX[$urandom_range(0, 6)]);
		end else begin
			foreach (pieces[i]) begin
				case (pieces[i])
					PC_LIT, PC_ESC: subj_bytes.insert(subj_bytes.size(), piece_chr[i]);
					PC_PCT, PC_STAR, PC_TAIL_STAR:
						repeat ($urandom_range(0, 3))
							subj_bytes.insert(subj_bytes.size(), pick_literal());
					PC_ONE: subj_bytes.insert(subj_bytes.size(), 8'($urandom_range(0, 255)));
					PC_STAR_LIT: subj_bytes.insert(subj_bytes.size(), CH_STAR);
					PC_SLASH_LIT: begin
						subj_bytes.insert(subj_bytes.size(), CH_SLASH);
						subj_bytes.insert(subj_bytes.size(), piece_chr[i]);
					end
					default: subj_bytes.insert(subj_bytes.size(), CH_SLASH);
				endcase
			end
			if (pick >= 6) begin
				pos = $urandom_range(0, subj_bytes.size());
				case ($urandom_range(0, 2))
					0: if (pos < subj_bytes.size())
						subj_bytes[pos] = 8'h61 + 8'($urandom_range(0, 3));
					1: if (pos < subj_bytes.size())
						subj_bytes.delete(pos);
					default: subj_bytes.insert(pos, 8'h61 + 8'($urandom_range(0, 3)));
				endcase
			end
		end
		foreach (subj_bytes[i])
			send(REQ_SUBJ_BYTE, subj_bytes[i]);
		send(REQ_SUBJ_END, 8'($urandom_range(0, 255)));
	endtask

	// One well-formed sequence: a pattern, an optional close (a subject byte
	// closes it too), sometimes a repeated close, then a few subjects.
	task automatic run_sequence(bit long_pattern);
		int unsigned n_subj;
		make_pattern(long_pattern ? $urandom_range(66, 80) : $urandom_range(0, 7));
		n_subj = $urandom_range(0, 4);
		if (n_subj == 0 || $urandom_range(0, 9) < 7)
			send(REQ_PAT_END, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 7) == 0)
			send(REQ_PAT_END, 8'($urandom_range(0, 255)));
		repeat (n_subj)
			make_subject();
	endtask

	// Arbitrary beats, then a close so the next sequence starts a fresh pattern.
	task automatic run_noise();
		repeat ($urandom_range(3, 10))
			send(req_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
		send(REQ_PAT_END, 8'($urandom_range(0, 255)));
	endtask

	// Waits until the input queue is drained, no beat is on the wire and no
	// verdict is outstanding; then it idles on, since pattern beats still move
	// through the pipeline without producing anything.
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || item_ch.valid || verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_invert(logic v);
		wait_quiet();
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Input driver: bursts of random length separated by random gaps. A beat
	// on the wire is held until the cycle after it was taken.
	// ------------------------------------------------------------------
	logic item_took = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;

	always @(negedge clk) begin
		if (arst_n && !(item_ch.valid && !item_took)) begin
			if (gap_left > 0 || pending_beats.size() == 0) begin
				item_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				item_ch.valid <= 1'b1;
				item_ch.payload <= pending_beats[0];
				pending_beats.delete(0);
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Result sink: stretches of steady ready, hard stalls and coin-flip ready.
	rx_mode_t rx_mode = RX_STEADY;
	int       rx_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'(2'($urandom_range(0, 2)));
				rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 12) : $urandom_range(1, 30);
			end
			rx_left--;
			case (rx_mode)
				RX_STEADY: result_ch.ready <= 1'b1;
				RX_STALL:  result_ch.ready <= 1'b0;
				default:   result_ch.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge. A result beat is
	// checked before this edge's input beat updates the model, so a stray
	// result can never be paired with an expectation made at the same edge.
	// ------------------------------------------------------------------
	int unsigned errors = 0;
	int unsigned beats_in = 0;
	int unsigned verdicts_seen = 0;
	int unsigned hits_seen = 0;
	int unsigned ovf_verdicts = 0;
	bit          saw_invert [2] = '{1'b0, 1'b0};

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.payload;
				if (verdicts.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, got match=%0b ovf=%0b",
						$time, got.match_result, got.pattern_overflow);
				end else begin
					want = verdicts[0];
					verdicts.delete(0);
					verdicts_seen++;
					if (got.match_result)
						hits_seen++;
					if (got.pattern_overflow)
						ovf_verdicts++;
					if (got.match_result !== want.match_result) begin
						errors++;
						$display("%0t: match_result mismatch, expected %0b, got %0b",
							$time, want.match_result, got.match_result);
					end
					if (got.pattern_overflow !== want.pattern_overflow) begin
						errors++;
						$display("%0t: pattern_overflow mismatch, expected %0b, got %0b",
							$time, want.pattern_overflow, got.pattern_overflow);
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				invert_on = cfg_ch.payload;
				saw_invert[cfg_ch.payload] = 1'b1;
			end
			if (item_ch.valid && item_ch.ready) begin
				beats_in++;
				predict_beat(item_ch.payload);
			end
			item_took <= item_ch.valid && item_ch.ready;
		end
	end

	// Watchdog on the whole run.
	int unsigned cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d beats queued, %0d verdicts outstanding",
				$time, cycles, pending_beats.size(), verdicts.size());
			$display("** like_pattern_matcher: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int unsigned phase_start;
		bit          first_seq;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		write_invert(1'b0);

		// Directed part. Zero byte and a slash held at pattern end, closed
		// twice; the second close must be ignored.
		send(REQ_PAT_BYTE, 8'h00);
		send(REQ_PAT_BYTE, CH_SLASH);
		send(REQ_PAT_END, 8'hFF);
		send(REQ_PAT_END, 8'h00);
		send(REQ_SUBJ_BYTE, 8'h00);
		send(REQ_SUBJ_BYTE, CH_SLASH);
		send(REQ_SUBJ_END, 8'hFF);
		// Same pattern again after the positions restart, with an empty subject.
		send(REQ_SUBJ_END, 8'h00);
		// New pattern with a held star that a subject byte closes as a run.
		send(REQ_PAT_BYTE, 8'hFF);
		send(REQ_PAT_BYTE, CH_STAR);
		send(REQ_SUBJ_BYTE, 8'hFF);
		send(REQ_SUBJ_BYTE, 8'h78);
		send(REQ_SUBJ_END, 8'hA5);
		// Underscore, double star, escaped percent and a slash before a letter.
		send(REQ_PAT_BYTE, CH_UNDER);
		send(REQ_PAT_BYTE, CH_STAR);
		send(REQ_PAT_BYTE, CH_STAR);
		send(REQ_PAT_BYTE, CH_SLASH);
		send(REQ_PAT_BYTE, CH_PERCENT);
		send(REQ_PAT_BYTE, CH_SLASH);
		send(REQ_PAT_BYTE, 8'h71);
		send(REQ_SUBJ_BYTE, 8'h7A);
		send(REQ_SUBJ_BYTE, CH_STAR);
		send(REQ_SUBJ_BYTE, CH_PERCENT);
		send(REQ_SUBJ_BYTE, CH_SLASH);
		send(REQ_SUBJ_BYTE, 8'h71);
		send(REQ_SUBJ_END, 8'h5A);

		// Random part in four phases, flipping invert_mode between them. Each
		// phase opens with a pattern long enough to overflow the token store.
		for (int ph = 0; ph < 4; ph++) begin
			write_invert((ph % 2) == 0);
			phase_start = beats_queued;
			first_seq = 1'b1;
			while (beats_queued - phase_start < 150) begin
				if (first_seq || $urandom_range(0, 24) == 0)
					run_sequence(1'b1);
				else if ($urandom_range(0, 9) == 0)
					run_noise();
				else
					run_sequence(1'b0);
				first_seq = 1'b0;
			end
		end

		wait_quiet();
		repeat (10) @(negedge clk);
		$display("Covered %0d input beats and %0d verdicts (%0d reported a hit, %0d overflowed)",
			beats_in, verdicts_seen, hits_seen, ovf_verdicts);
		$display("invert_mode exercised at 0: %0b, at 1: %0b; %0d check failures",
			saw_invert[0], saw_invert[1], errors);
		if (errors == 0)
			$display("** like_pattern_matcher: PASSED **");
		else
			$display("** like_pattern_matcher: FAILED **");
		$finish;
	end

endmodule
